### src/keyed_value_table_compacting_core_assert.svh
// ----------------------------------------------------------------------------
// keyed value table assertion macros
// concurrent checks on i_clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef KEYED_VALUE_TABLE_COMPACTING_CORE_ASSERT_SVH
`define KEYED_VALUE_TABLE_COMPACTING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KVT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("kvt assertion failed");

// next-cycle implication
`define KVT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("kvt assertion failed");

`else

`define KVT_ASSERT_IMP(label, ante, cons)
`define KVT_ASSERT_NXT(label, ante, cons)

`endif

`endif

### src/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// shared types, constants and helpers of the keyed value table
// ----------------------------------------------------------------------------
package kvt_pkg;

    // table geometry
    localparam int SLOTS  = 64;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CAP_W  = 7;
    localparam int CMP_W  = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

    // configuration register map
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_PRESENT  = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] new_value;
    } t_in_word;

    // result word
    typedef struct packed {
        logic        ok;
        logic [31:0] found_value;
        logic [6:0]  entry_count;
    } t_out_word;

    // one stored pair
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] value;
    } t_entry;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             present;
    } t_cfg;

    // kind of result to build
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FAIL,
        RES_OK,
        RES_FOUND
    } t_res_kind;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      insert;
        logic      search;
        logic      shift_init;
        logic      shift;
        logic      shrink;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic       present;
        logic       key_nz;
        logic [1:0] mode;
        logic       room;
        logic       ptr_end;
        logic       rd_vld;
        logic       hit;
    } t_dp_status;

    // clear every byte after the first zero byte, from the top byte down
    function automatic logic [31:0] norm_key(input logic [31:0] k);
        logic [31:0] res;
        logic        live;
        res  = '0;
        live = 1'b1;
        for (int b = 3; b >= 0; b--) begin
            if (k[8*b +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                res[8*b +: 8] = k[8*b +: 8];
            end
        end
        return res;
    endfunction

endpackage

### src/kvt_regs.sv
// ----------------------------------------------------------------------------
// kvt_regs
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module kvt_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output kvt_pkg::t_cfg o_cfg
);
    import kvt_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic             r_present;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_present  <= 1'b1;
        end else if (wr_en) begin
            case (paddr[2])
                REG_CAPACITY: r_capacity <= pwdata[CAP_W-1:0];
                REG_PRESENT:  r_present  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, r_capacity};
            REG_PRESENT:  prdata = {31'd0, r_present};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.capacity = r_capacity;
    assign o_cfg.present  = r_present;

endmodule

### src/kvt_dp.sv
// ----------------------------------------------------------------------------
// kvt_dp
// datapath: entry memory, search and shift pointers, result register
// ----------------------------------------------------------------------------
module kvt_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kvt_pkg::t_in_word   i_in_data,
    input  kvt_pkg::t_cfg       i_cfg,
    input  kvt_pkg::t_dp_cmd    i_cmd,
    output kvt_pkg::t_dp_status o_status,
    output kvt_pkg::t_out_word  o_out_data
);
    import kvt_pkg::*;

    // entry memory
    t_entry mem [SLOTS];

    logic [31:0]      r_key;
    logic [31:0]      r_value;
    logic [1:0]       r_mode;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_ptr;
    logic             r_rd_vld;
    logic [ADDR_W-1:0] r_rd_addr;
    t_entry           r_rd_data;
    t_out_word        r_res;

    logic              ptr_lt;
    logic              issue;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_entry            wdata;
    logic [CMP_W-1:0]  eff_cap;

    assign ptr_lt = r_ptr < r_count;
    assign issue  = (i_cmd.search || i_cmd.shift) && ptr_lt;

    // effective capacity is the register limited to the table size
    assign eff_cap = (CMP_W'(i_cfg.capacity) < CMP_W'(SLOTS)) ?
                     CMP_W'(i_cfg.capacity) : CMP_W'(SLOTS);

    // write port: append on insert, move each entry down one slot while shifting
    assign we    = i_cmd.insert || (i_cmd.shift && r_rd_vld);
    assign waddr = i_cmd.insert ? r_count[ADDR_W-1:0] : (r_rd_addr - ADDR_W'(1));
    assign wdata = i_cmd.insert ? t_entry'{key: r_key, value: r_value} : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (issue) begin
            r_rd_data <= mem[r_ptr[ADDR_W-1:0]];
            r_rd_addr <= r_ptr[ADDR_W-1:0];
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= norm_key(i_in_data.key);
            r_value <= i_in_data.new_value;
            r_mode  <= i_in_data.mode;
        end
    end

    // count, pointer and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.shrink) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.shift_init) begin
                r_ptr    <= CNT_W'(r_rd_addr) + CNT_W'(1);
                r_rd_vld <= 1'b0;
            end else begin
                if (issue) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                r_rd_vld <= issue;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_kind)
                RES_ZERO:  r_res <= '{ok: 1'b0, found_value: 32'd0, entry_count: 7'd0};
                RES_FAIL:  r_res <= '{ok: 1'b0, found_value: 32'd0,
                                      entry_count: 7'(r_count)};
                RES_OK:    r_res <= '{ok: 1'b1, found_value: 32'd0,
                                      entry_count: 7'(r_count)};
                RES_FOUND: r_res <= '{ok: 1'b1, found_value: r_rd_data.value,
                                      entry_count: 7'(r_count)};
                default:   r_res <= '0;
            endcase
        end
    end

    assign o_out_data = r_res;

    // status to controller
    assign o_status.present = i_cfg.present;
    assign o_status.key_nz  = (r_key != 32'd0);
    assign o_status.mode    = r_mode;
    assign o_status.room    = (CMP_W'(r_count) + CMP_W'(1)) < eff_cap;
    assign o_status.ptr_end = !ptr_lt;
    assign o_status.rd_vld  = r_rd_vld;
    assign o_status.hit     = r_rd_vld && (r_rd_data.key == r_key);

endmodule

### src/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// controller: sequences decode, search, shift and result hand-off
// ----------------------------------------------------------------------------
module kvt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  kvt_pkg::t_dp_status i_status,
    output kvt_pkg::t_dp_cmd    o_cmd
);
    import kvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state    r_state, n_state;
    t_res_kind r_kind, n_kind;
    logic      r_out_valid, n_out_valid;
    logic      out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.res_kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                if (!i_status.present) begin
                    n_kind = RES_ZERO;
                end else if (!i_status.key_nz) begin
                    n_kind = RES_FAIL;
                end else begin
                    case (i_status.mode)
                        MODE_INSERT: begin
                            o_cmd.insert = i_status.room;
                            n_kind       = i_status.room ? RES_OK : RES_FAIL;
                        end
                        MODE_LOOKUP, MODE_REMOVE: begin
                            n_state = S_SEARCH;
                        end
                        default: n_kind = RES_FAIL;
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_status.hit) begin
                    if (i_status.mode == MODE_LOOKUP) begin
                        n_kind  = RES_FOUND;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end
                end else if (i_status.ptr_end && !i_status.rd_vld) begin
                    n_kind  = RES_FAIL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.search = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_status.ptr_end && !i_status.rd_vld) begin
                    o_cmd.shrink = 1'b1;
                    n_kind       = RES_OK;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= RES_FAIL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/keyed_value_table_compacting_core.sv
// ----------------------------------------------------------------------------
// keyed_value_table_compacting_core
// packed key/value table with insert, first-match lookup and compacting remove
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        in         i_in_valid/o_in_stall  i_in_data  (mode, key, new_value)
//  out       out        o_out_valid/i_out_stall o_out_data (ok, found_value, entry_count)
//  config    in         apb psel/penable       capacity @0x0, table_present @0x4
//
//  one word at a time; an insert or a word refused at decode goes straight from
//  decode to the result, a lookup or a remove first searches the entries in order,
//  and a remove then shifts the later entries down:
//  the single read port steps one entry per cycle through search, then shift
//  a new word is taken while a finished result waits on a stalled output
//  reset clears the entry count; the entry memory itself is not cleared
// ----------------------------------------------------------------------------
`include "keyed_value_table_compacting_core_assert.svh"

module keyed_value_table_compacting_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kvt_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kvt_pkg::t_out_word o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import kvt_pkg::*;

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration registers
    kvt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer
    kvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // table datapath
    kvt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    // one word in flight: stall rises right after an accept
    `KVT_ASSERT_NXT(a_stall_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a failed result never carries a value
    `KVT_ASSERT_IMP(a_fail_no_value, o_out_valid && !o_out_data.ok, o_out_data.found_value == 32'd0)

    // an append only happens with room left
    `KVT_ASSERT_IMP(a_insert_has_room, cmd.insert, status.room && status.present)

    // the shift never starts without a match
    `KVT_ASSERT_IMP(a_shift_on_hit, cmd.shift_init, status.hit)

endmodule

### bench/kvt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kvt_checker
// watches the word channels and the register port of the keyed value table,
// keeps its own copy of the table and compares every result word in order
// ----------------------------------------------------------------------------
module kvt_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  kvt_pkg::t_in_word   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  kvt_pkg::t_out_word  i_out_data,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);
    import kvt_pkg::*;

    // shadow copy of the table and its registers
    logic [31:0]      key_tab [SLOTS];
    logic [31:0]      val_tab [SLOTS];
    int               n_entries   = 0;
    logic [CAP_W-1:0] cap_reg     = CAP_RESET;
    logic             present_reg = 1'b1;
    t_out_word        due_results [$];
    int               fail_count  = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // string-style key: everything from the first zero byte down is dropped
    function automatic logic [31:0] canon_key(input logic [31:0] k);
        logic [31:0] keep;
        keep = '1;
        for (int b = 3; b >= 0; b--) begin
            if (k[8*b +: 8] == 8'd0) begin
                keep = keep & ~(32'hFFFF_FFFF >> (8 * (3 - b)));
            end
        end
        return k & keep;
    endfunction

    // apply one word to the shadow table and return the result it should give
    function automatic t_out_word run_table_op(input t_in_word w);
        t_out_word   r;
        logic [31:0] k;
        int          hit;
        int          lim;
        r = '0;
        k = canon_key(w.key);
        if (!present_reg) begin
            return r;
        end
        hit = -1;
        for (int i = 0; i < n_entries; i++) begin
            if (hit < 0 && key_tab[i] == k) begin
                hit = i;
            end
        end
        lim = (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
        if (k != 32'd0) begin
            case (w.mode)
                MODE_INSERT: begin
                    if (n_entries + 1 < lim) begin
                        key_tab[n_entries] = k;
                        val_tab[n_entries] = w.new_value;
                        n_entries++;
                        r.ok = 1'b1;
                    end
                end
                MODE_LOOKUP: begin
                    if (hit >= 0) begin
                        r.ok          = 1'b1;
                        r.found_value = val_tab[hit];
                    end
                end
                MODE_REMOVE: begin
                    if (hit >= 0) begin
                        // close the gap left by the removed pair
                        for (int i = hit; i + 1 < n_entries; i++) begin
                            key_tab[i] = key_tab[i + 1];
                            val_tab[i] = val_tab[i + 1];
                        end
                        n_entries--;
                        r.ok = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.entry_count = n_entries[6:0];
        return r;
    endfunction

    // sample both channels and the register port on every rising clock edge
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (!i_rst_n) begin
            n_entries   = 0;
            cap_reg     = CAP_RESET;
            present_reg = 1'b1;
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_CAPACITY) begin
                    cap_reg = i_pwdata[CAP_W-1:0];
                end else begin
                    present_reg = i_pwdata[0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due_results.push_back(run_table_op(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (due_results.size() == 0) begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, got.ok);
                        fail_count++;
                    end
                    if (got.found_value !== want.found_value) begin
                        $error("found_value: expected %h, actual %h",
                               want.found_value, got.found_value);
                        fail_count++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, got.entry_count);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fail_count;
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives the keyed value table with a directed opening and random phases
// over several capacity and presence settings; the checker judges results
// ----------------------------------------------------------------------------
module tb_top;
    import kvt_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 150;
    localparam int         N_PHASES     = 9;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int in_idle_pct  = 21;
    int out_idle_pct = 54;
    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // short keys that recur, so lookups and removes often hit
    logic [31:0] key_pool [8] = '{32'h6162_0000, 32'h6364_6500, 32'h7800_0000,
                                  32'h6B65_7931, 32'h7A7A_0000, 32'h7100_0000,
                                  32'h4100_0000, 32'hFFFF_FFFF};

    // per phase: capacity, presence, word count, insert share in percent
    int cap_seq  [N_PHASES] = '{64, 64, 2, 0, 127, 1, 64, 10, 64};
    int pres_seq [N_PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1, 1};
    int len_seq  [N_PHASES] = '{60, 50, 40, 25, 50, 20, 20, 50, 60};
    int ins_seq  [N_PHASES] = '{70, 35, 40, 50, 60, 50, 50, 45, 30};

    always #5 clk = ~clk;

    keyed_value_table_compacting_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    kvt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // give up when nothing moves on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, with a random gap first, and hold it until taken
    task automatic send_op(input logic [1:0] mode, input logic [31:0] key,
                           input logic [31:0] value);
        if ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
        end
        in_valid          <= 1'b1;
        in_data.mode      <= mode;
        in_data.key       <= key;
        in_data.new_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic idx, input logic [31:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // pool key with junk after its terminator, an empty key, or pure noise
    function automatic logic [31:0] make_key();
        logic [31:0] k;
        logic        zero_seen;
        int          r;
        r = $urandom_range(0, 99);
        k = $urandom();
        if (r < 8) begin
            return k;
        end
        if (r < 14) begin
            k[31:24] = 8'd0;
            return k;
        end
        k         = key_pool[$urandom_range(0, 7)];
        zero_seen = 1'b0;
        for (int b = 3; b >= 0; b--) begin
            if (zero_seen && $urandom_range(0, 1) == 1) begin
                k[8*b +: 8] = 8'($urandom_range(0, 255));
            end
            if (k[8*b +: 8] == 8'd0) begin
                zero_seen = 1'b1;
            end
        end
        return k;
    endfunction

    function automatic logic [1:0] pick_mode(input int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            return MODE_INSERT;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return MODE_LOOKUP;
        end else if (r < 93) begin
            return MODE_REMOVE;
        end
        return MODE_UNUSED;
    endfunction

    // stimulus and verdict
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, refused empty key, terminator handling, duplicates
        send_op(MODE_LOOKUP, 32'h6162_0000, 32'h0);
        send_op(MODE_REMOVE, 32'h6162_0000, 32'h0);
        send_op(MODE_INSERT, 32'h00FF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 32'h4100_7879, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(MODE_INSERT, 32'h4100_0000, 32'h0000_0001);
        send_op(MODE_LOOKUP, 32'h4100_1234, 32'hFFFF_FFFF);
        send_op(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_REMOVE, 32'h4100_0000, 32'h0);
        send_op(MODE_LOOKUP, 32'h4100_0000, 32'h0);
        send_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_op(MODE_REMOVE, 32'h1234_5678, 32'h0);
        send_op(MODE_REMOVE, 32'h00AB_CDEF, 32'h0);
        send_op(MODE_LOOKUP, 32'h0000_0000, 32'h0);

        // full table with a small capacity
        wait_idle();
        write_reg(REG_CAPACITY, 32'd3);
        send_op(MODE_INSERT, 32'h6200_0000, 32'h5A5A_5A5A);
        send_op(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_op(MODE_INSERT, 32'h6200_0000, 32'hA5A5_A5A5);
        send_op(MODE_INSERT, 32'h6300_0000, 32'h1111_1111);

        // table absent, then back with its contents
        wait_idle();
        write_reg(REG_PRESENT, 32'd0);
        send_op(MODE_LOOKUP, 32'h6200_0000, 32'h0);
        send_op(MODE_INSERT, 32'h6400_0000, 32'h2222_2222);
        send_op(MODE_UNUSED, 32'h6200_0000, 32'h0);
        wait_idle();
        write_reg(REG_PRESENT, 32'd1);
        send_op(MODE_LOOKUP, 32'h6200_0000, 32'h0);

        // random phases over several settings
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                in_idle_pct  = 54;
                out_idle_pct = 21;
            end else if (p == 6) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            wait_idle();
            write_reg(REG_CAPACITY, cap_seq[p]);
            write_reg(REG_PRESENT, pres_seq[p]);
            for (int n = 0; n < len_seq[p]; n++) begin
                send_op(pick_mode(ins_seq[p]), make_key(), $urandom());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
